FILE: sv/afsk_pkg.sv
// package for the afsk tone modulator: word types, codes and sine table
`default_nettype none
package afsk_pkg;

	// opcodes of an input word
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_STOP  = 2'd2;

	// configuration register indexes
	localparam int unsigned CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] REG_MARK_INC  = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SPACE_INC = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_SPB       = 2'd2;

	localparam int unsigned PHASE_W = 32;
	localparam int unsigned COUNT_W = 6;
	localparam int unsigned DUTY_W  = 8;
	localparam int unsigned CFG_DATA_W = PHASE_W;

	localparam logic [PHASE_W-1:0] MARK_INC_RESET  = 32'd107374182;
	localparam logic [PHASE_W-1:0] SPACE_INC_RESET = 32'd196852667;
	localparam logic [COUNT_W-1:0] SPB_RESET       = 6'd40;

	typedef struct packed {
		logic [1:0] opcode;
		logic       tx_bit;
		logic       bit_available;
	} afsk_in_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              bit_taken;
		logic              active;
		logic              ptt_release;
	} afsk_out_t;

	// round(127.5 + 127.5*sin(2*pi*i/256))
	localparam logic [DUTY_W-1:0] SINE_ROM [256] = '{
		8'd128, 8'd131, 8'd134, 8'd137, 8'd140, 8'd143, 8'd146, 8'd149,
		8'd152, 8'd155, 8'd158, 8'd162, 8'd165, 8'd167, 8'd170, 8'd173,
		8'd176, 8'd179, 8'd182, 8'd185, 8'd188, 8'd190, 8'd193, 8'd196,
		8'd198, 8'd201, 8'd203, 8'd206, 8'd208, 8'd211, 8'd213, 8'd215,
		8'd218, 8'd220, 8'd222, 8'd224, 8'd226, 8'd228, 8'd230, 8'd232,
		8'd234, 8'd235, 8'd237, 8'd238, 8'd240, 8'd241, 8'd243, 8'd244,
		8'd245, 8'd246, 8'd248, 8'd249, 8'd250, 8'd250, 8'd251, 8'd252,
		8'd253, 8'd253, 8'd254, 8'd254, 8'd254, 8'd255, 8'd255, 8'd255,
		8'd255, 8'd255, 8'd255, 8'd255, 8'd254, 8'd254, 8'd254, 8'd253,
		8'd253, 8'd252, 8'd251, 8'd250, 8'd250, 8'd249, 8'd248, 8'd246,
		8'd245, 8'd244, 8'd243, 8'd241, 8'd240, 8'd238, 8'd237, 8'd235,
		8'd234, 8'd232, 8'd230, 8'd228, 8'd226, 8'd224, 8'd222, 8'd220,
		8'd218, 8'd215, 8'd213, 8'd211, 8'd208, 8'd206, 8'd203, 8'd201,
		8'd198, 8'd196, 8'd193, 8'd190, 8'd188, 8'd185, 8'd182, 8'd179,
		8'd176, 8'd173, 8'd170, 8'd167, 8'd165, 8'd162, 8'd158, 8'd155,
		8'd152, 8'd149, 8'd146, 8'd143, 8'd140, 8'd137, 8'd134, 8'd131,
		8'd128, 8'd124, 8'd121, 8'd118, 8'd115, 8'd112, 8'd109, 8'd106,
		8'd103, 8'd100, 8'd97,  8'd93,  8'd90,  8'd88,  8'd85,  8'd82,
		8'd79,  8'd76,  8'd73,  8'd70,  8'd67,  8'd65,  8'd62,  8'd59,
		8'd57,  8'd54,  8'd52,  8'd49,  8'd47,  8'd44,  8'd42,  8'd40,
		8'd37,  8'd35,  8'd33,  8'd31,  8'd29,  8'd27,  8'd25,  8'd23,
		8'd21,  8'd20,  8'd18,  8'd17,  8'd15,  8'd14,  8'd12,  8'd11,
		8'd10,  8'd9,   8'd7,   8'd6,   8'd5,   8'd5,   8'd4,   8'd3,
		8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,   8'd1,   8'd2,
		8'd2,   8'd3,   8'd4,   8'd5,   8'd5,   8'd6,   8'd7,   8'd9,
		8'd10,  8'd11,  8'd12,  8'd14,  8'd15,  8'd17,  8'd18,  8'd20,
		8'd21,  8'd23,  8'd25,  8'd27,  8'd29,  8'd31,  8'd33,  8'd35,
		8'd37,  8'd40,  8'd42,  8'd44,  8'd47,  8'd49,  8'd52,  8'd54,
		8'd57,  8'd59,  8'd62,  8'd65,  8'd67,  8'd70,  8'd73,  8'd76,
		8'd79,  8'd82,  8'd85,  8'd88,  8'd90,  8'd93,  8'd97,  8'd100,
		8'd103, 8'd106, 8'd109, 8'd112, 8'd115, 8'd118, 8'd121, 8'd124
	};

endpackage
`default_nettype wire

FILE: sv/afsk_tone_modulator_top.sv
// afsk tone modulator: input register, phase/state update and result register
// an accepted word passes the input register, then the result register; out_stall holds both
// throughput: one word per cycle unless stalled; phase add and sine lookup share one stage
// the modulator state updates when a word leaves the input register, so the next word sees it
// reset: idle, phase and tick count zero, held bit one, duty zero, registers at defaults
// both pipeline registers empty after reset
`default_nettype none
module afsk_tone_modulator_top (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_write,
	input  wire logic [afsk_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  wire logic [afsk_pkg::CFG_DATA_W-1:0]       cfg_data,
	// input channel
	input  wire logic                                  in_valid,
	output logic                                       in_stall,
	input  wire afsk_pkg::afsk_in_t                    in_word,
	// output channel
	output logic                                       out_valid,
	input  wire logic                                  out_stall,
	output afsk_pkg::afsk_out_t                        out_word
);

	// configuration registers
	logic [afsk_pkg::PHASE_W-1:0] mark_inc_q;
	logic [afsk_pkg::PHASE_W-1:0] space_inc_q;
	logic [afsk_pkg::COUNT_W-1:0] spb_q;

	// modulator state
	logic                         transmitting_q;
	logic [afsk_pkg::PHASE_W-1:0] phase_q;
	logic [afsk_pkg::COUNT_W-1:0] tick_count_q;
	logic                         held_bit_q;
	logic [afsk_pkg::DUTY_W-1:0]  held_duty_q;

	// input register
	logic                         valid_s1;
	afsk_pkg::afsk_in_t           word_s1;

	// result register
	logic                         out_valid_q;
	afsk_pkg::afsk_out_t          out_word_q;

	logic                         advance;

	// next-state values of the word in the input register
	logic                         transmitting_d;
	logic [afsk_pkg::PHASE_W-1:0] phase_d;
	logic [afsk_pkg::COUNT_W-1:0] tick_count_d;
	logic                         held_bit_d;
	logic [afsk_pkg::DUTY_W-1:0]  held_duty_d;
	logic                         taken_d;
	logic                         release_d;

	logic                         bit_sel;
	logic [afsk_pkg::PHASE_W-1:0] phase_sum;
	logic [afsk_pkg::COUNT_W-1:0] count_inc;

	// result register frees up when empty or being taken
	assign advance   = !out_valid_q || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

	// configuration writes, unknown index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_inc_q  <= afsk_pkg::MARK_INC_RESET;
			space_inc_q <= afsk_pkg::SPACE_INC_RESET;
			spb_q       <= afsk_pkg::SPB_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				afsk_pkg::REG_MARK_INC:  mark_inc_q  <= cfg_data;
				afsk_pkg::REG_SPACE_INC: space_inc_q <= cfg_data;
				afsk_pkg::REG_SPB:       spb_q       <= cfg_data[afsk_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			word_s1 <= in_word;
		end
	end

	// a new bit is latched at a bit boundary, otherwise the held one keys the tone
	assign bit_sel   = (tick_count_q == '0) ? word_s1.tx_bit : held_bit_q;
	assign phase_sum = phase_q + (bit_sel ? mark_inc_q : space_inc_q);
	assign count_inc = tick_count_q + afsk_pkg::COUNT_W'(1);

	always_comb begin
		transmitting_d = transmitting_q;
		phase_d        = phase_q;
		tick_count_d   = tick_count_q;
		held_bit_d     = held_bit_q;
		held_duty_d    = held_duty_q;
		taken_d        = 1'b0;
		release_d      = 1'b0;
		case (word_s1.opcode)
			afsk_pkg::OP_START: begin
				phase_d        = '0;
				tick_count_d   = '0;
				transmitting_d = 1'b1;
			end
			afsk_pkg::OP_STOP: begin
				transmitting_d = 1'b0;
				tick_count_d   = '0;
				held_duty_d    = '0;
			end
			afsk_pkg::OP_TICK: begin
				if (transmitting_q) begin
					if (tick_count_q == '0 && !word_s1.bit_available) begin
						// packet done: drop the carrier and release ptt
						transmitting_d = 1'b0;
						tick_count_d   = '0;
						held_duty_d    = '0;
						release_d      = 1'b1;
					end else begin
						if (tick_count_q == '0) begin
							held_bit_d = word_s1.tx_bit;
							taken_d    = 1'b1;
						end
						phase_d      = phase_sum;
						held_duty_d  = afsk_pkg::SINE_ROM[phase_sum[afsk_pkg::PHASE_W-1 -:
							afsk_pkg::DUTY_W]];
						// zero samples per bit behaves like one
						tick_count_d = (count_inc >= spb_q) ? '0 : count_inc;
					end
				end
			end
			default: ;  // unused opcode acts as an idle tick
		endcase
	end

	// modulator state moves with the word leaving the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transmitting_q <= 1'b0;
			phase_q        <= '0;
			tick_count_q   <= '0;
			held_bit_q     <= 1'b1;
			held_duty_q    <= '0;
		end else if (valid_s1 && advance) begin
			transmitting_q <= transmitting_d;
			phase_q        <= phase_d;
			tick_count_q   <= tick_count_d;
			held_bit_q     <= held_bit_d;
			held_duty_q    <= held_duty_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance) begin
			out_word_q.duty        <= held_duty_d;
			out_word_q.bit_taken   <= taken_d;
			out_word_q.active      <= transmitting_d;
			out_word_q.ptt_release <= release_d;
		end
	end

endmodule
`default_nettype wire
